### rtl/crcfb_pkg.sv
package crcfb_pkg;

   localparam int DEF_BUF_DEPTH = 64;
   localparam int LEN_W = 7;
   localparam int CRC_W = 16;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_BEGIN   = 2'd0,
      OP_ADD     = 2'd1,
      OP_FINISH  = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ERR       = 2'd1,
      ST_NOT_READY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic wr_hi;
      logic wr_lo;
      logic stream;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fin_ok;
      logic rd_end;
   } dp_stat_type;

   // One byte folded into a CRC-16/CCITT register, MSB first.
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != '0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/crcfb_ctrl.sv
module crcfb_ctrl
   import crcfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_opcode,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd,
   output logic        busy
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_WR_HI  = 4'b0010,
      S_WR_LO  = 4'b0100,
      S_STREAM = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && (state_ff == S_IDLE);

   assign cmd.accept = accept;
   assign cmd.wr_hi  = (state_ff == S_WR_HI);
   assign cmd.wr_lo  = (state_ff == S_WR_LO);
   assign cmd.stream = (state_ff == S_STREAM);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (op_type'(req_opcode) == OP_FINISH) && stat.fin_ok) begin
               state_in = S_WR_HI;
            end
         end
         S_WR_HI: begin
            state_in = S_WR_LO;
         end
         S_WR_LO: begin
            state_in = S_STREAM;
         end
         S_STREAM: begin
            if (stat.rd_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/crcfb_dpath.sv
module crcfb_dpath
   import crcfb_pkg::*;
#(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  ctl_cmd_type      cmd,
   input  logic [1:0]       req_opcode,
   input  logic [7:0]       req_data_byte,
   input  logic             req_frame_kind,
   output dp_stat_type      stat,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last,
   output logic [LEN_W-1:0] rsp_length,
   output logic [CRC_W-1:0] rsp_crc_value,
   output logic             rsp_kind_out
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUF_DEPTH);

   logic [7:0]       mem [BUF_DEPTH];
   logic [7:0]       rd_data_ff;

   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [CRC_W-1:0] crc_ff, crc_in;
   logic             bflag_ff, bflag_in;
   logic             kind_ff, kind_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic             valid_ff, valid_in;
   status_type       status_ff, status_in;
   logic             last_ff, last_in;
   logic             sel_ff, sel_in;

   logic             mem_we;
   logic [7:0]       mem_wd;
   logic             rd_en;

   assign stat.fin_ok = (fill_ff + 7'd1) < DEPTH_LEN;
   assign stat.rd_end = LEN_W'(rd_idx_ff) == (fill_ff - 7'd1);

   always_comb begin
      fill_in   = fill_ff;
      crc_in    = crc_ff;
      bflag_in  = bflag_ff;
      kind_in   = kind_ff;
      rd_idx_in = rd_idx_ff;
      valid_in  = 1'b0;
      status_in = ST_OK;
      last_in   = 1'b1;
      sel_in    = 1'b0;
      mem_we    = 1'b0;
      mem_wd    = req_data_byte;
      rd_en     = 1'b0;

      if (cmd.accept) begin
         case (op_type'(req_opcode))
            OP_BEGIN: begin
               valid_in = 1'b1;
               if (bflag_ff) begin
                  status_in = ST_NOT_READY;
               end else begin
                  kind_in = req_frame_kind;
                  crc_in  = CRC_INIT;
                  fill_in = '0;
               end
            end
            OP_ADD: begin
               valid_in = 1'b1;
               if ((fill_ff >= DEPTH_LEN) || bflag_ff) begin
                  status_in = ST_ERR;
               end else begin
                  crc_in  = crc_fold(crc_ff, req_data_byte);
                  mem_we  = 1'b1;
                  fill_in = fill_ff + 7'd1;
               end
            end
            OP_FINISH: begin
               // A good finish produces its results from the stream state.
               if (!stat.fin_ok) begin
                  valid_in  = 1'b1;
                  status_in = ST_ERR;
               end
            end
            OP_RELEASE: begin
               valid_in = 1'b1;
               bflag_in = 1'b0;
            end
            default: begin
               valid_in = 1'b0;
            end
         endcase
      end

      if (cmd.wr_hi) begin
         mem_we  = 1'b1;
         mem_wd  = crc_ff[15:8];
         fill_in = fill_ff + 7'd1;
      end

      if (cmd.wr_lo) begin
         mem_we    = 1'b1;
         mem_wd    = crc_ff[7:0];
         fill_in   = fill_ff + 7'd1;
         rd_idx_in = '0;
         bflag_in  = 1'b1;
      end

      if (cmd.stream) begin
         rd_en     = 1'b1;
         rd_idx_in = rd_idx_ff + AW'(1);
         valid_in  = 1'b1;
         sel_in    = 1'b1;
         last_in   = stat.rd_end;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_ff[AW-1:0]] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         crc_ff    <= CRC_INIT;
         bflag_ff  <= 1'b0;
         kind_ff   <= 1'b0;
         rd_idx_ff <= '0;
         valid_ff  <= 1'b0;
         status_ff <= ST_OK;
         last_ff   <= 1'b1;
         sel_ff    <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         crc_ff    <= crc_in;
         bflag_ff  <= bflag_in;
         kind_ff   <= kind_in;
         rd_idx_ff <= rd_idx_in;
         valid_ff  <= valid_in;
         status_ff <= status_in;
         last_ff   <= last_in;
         sel_ff    <= sel_in;
      end
   end

   assign rsp_strobe     = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_frame_byte = sel_ff ? rd_data_ff : 8'h00;
   assign rsp_last       = last_ff;
   assign rsp_length     = fill_ff;
   assign rsp_crc_value  = crc_ff;
   assign rsp_kind_out   = kind_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_LEN)
      else $error("frame length beyond buffer depth");

   a_stream_continues: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |=> (valid_ff && sel_ff))
      else $error("frame stream broke off before its last beat");

   a_busy_after_crc: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_lo |=> bflag_ff)
      else $error("busy flag not set after CRC append");

   a_stream_ok: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (valid_ff && (status_ff == ST_OK)))
      else $error("streamed byte without ok status");

endmodule

### rtl/crc16_tx_frame_builder_top.sv
// Begin, add, release and a refused finish give one registered result beat in the cycle after accept.
// A good finish on N stored bytes streams N+2 beats, the first after the CRC-high and CRC-low writes
// and the registered buffer read, then one per cycle from the single frame buffer read port; busy holds
// until the last byte is read. Other commands can be accepted every cycle while busy is low.
// Reset is synchronous and active high: CRC 0xFFFF, length 0, flags clear, buffer contents undefined.
// The receiver cannot stall: each result beat is valid for exactly one cycle on rsp_strobe.
module crc16_tx_frame_builder_top
   import crcfb_pkg::*;
#(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_opcode,
   input  logic [7:0]       req_data_byte,
   input  logic             req_frame_kind,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last,
   output logic [LEN_W-1:0] rsp_length,
   output logic [CRC_W-1:0] rsp_crc_value,
   output logic             rsp_kind_out
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   crcfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   crcfb_dpath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .req_frame_kind (req_frame_kind),
      .stat           (stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last       (rsp_last),
      .rsp_length     (rsp_length),
      .rsp_crc_value  (rsp_crc_value),
      .rsp_kind_out   (rsp_kind_out)
   );

endmodule
